/* rtl/pse_pkg.sv */
// Package for the postfix stack evaluator: symbol codes, status codes,
// operation codes and the request struct passed to the arithmetic unit.
// No dependencies.
`default_nettype none

package pse_pkg;

    // ASCII symbols recognized on the input
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_SYMBOL = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW   = 3'd3;
    localparam logic [2:0] ST_DIV_ZERO   = 3'd4;
    localparam logic [2:0] ST_LEFTOVER   = 3'd5;

    // Arithmetic operation codes
    typedef logic [2:0] t_op;
    localparam t_op OP_ADD = 3'd0;
    localparam t_op OP_SUB = 3'd1;
    localparam t_op OP_MUL = 3'd2;
    localparam t_op OP_DIV = 3'd3;
    localparam t_op OP_REM = 3'd4;

    // Request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

endpackage

`default_nettype wire

/* rtl/postfix_stack_evaluator.sv */
// Postfix expression evaluator: value stack in a one-read-port memory,
// small sequencer, iterative arithmetic unit (pse_alu). Depends on pse_pkg.
// A symbol is taken only while the sequencer is idle. An operator reads both
// operands and runs pse_alu, whose * / and % use a one-bit-per-cycle loop; a zero
// divisor skips it. A terminator waits until the output register is free.
// Synchronous active-low reset empties the stack and clears any pending error.
`default_nettype none

module postfix_stack_evaluator import pse_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_symbol,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_value,
    output logic [2:0]       o_status
);

    localparam int W  = VALUE_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDR  = 3'd1;
    localparam logic [2:0] S_RDL  = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_TERM = 3'd4;

    logic [W-1:0]  mem [STACK_DEPTH];

    logic [2:0]    r_st, n_st;
    logic [DW-1:0] r_depth, n_depth;
    logic [2:0]    r_err, n_err;
    t_op           r_op, n_op;
    logic [W-1:0]  r_right, n_right;
    logic [W-1:0]  r_rd_data;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_value, n_value;
    logic [2:0]    r_status, n_status;

    logic          w_accept;
    logic          w_out_free;
    logic [AW-1:0] w_top_idx;
    logic [AW-1:0] w_below_idx;
    logic [AW-1:0] w_rd_addr;
    logic          w_we;
    logic [AW-1:0] w_wr_addr;
    logic [W-1:0]  w_wr_data;
    logic [3:0]    w_digit;
    t_alu_req      w_alu_req;
    logic          w_alu_done;
    logic [W-1:0]  w_alu_result;
    logic [2:0]    w_term_status;

    assign o_stall     = (r_st != S_IDLE);
    assign w_accept    = i_valid && (r_st == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_top_idx   = AW'(r_depth - DW'(1));
    assign w_below_idx = AW'(r_depth - DW'(2));
    assign w_digit     = 4'(i_symbol - CH_ZERO);

    // terminator status: first error wins, then the final depth check
    assign w_term_status = (r_err != ST_OK)      ? r_err :
                           (r_depth != DW'(1))   ? ST_LEFTOVER : ST_OK;

    // read address: top on an operator or entry 0 on a terminator, then below top
    assign w_rd_addr = (r_st == S_RDR) ? w_below_idx :
                       (i_symbol == CH_NUL) ? '0 : w_top_idx;

    // main sequencer
    always_comb begin
        n_st        = r_st;
        n_depth     = r_depth;
        n_err       = r_err;
        n_op        = r_op;
        n_right     = r_right;
        n_value     = r_value;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_stall;
        w_we        = 1'b0;
        w_wr_addr   = r_depth[AW-1:0];
        w_wr_data   = W'(w_digit);
        w_alu_req   = '{start: 1'b0, op: r_op};
        unique case (r_st)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_symbol == CH_NUL) begin
                        n_st = S_TERM;
                    end else if (r_err == ST_OK) begin
                        case (i_symbol) inside
                            [CH_ZERO:CH_NINE]: begin
                                if (r_depth == DW'(STACK_DEPTH)) begin
                                    n_err = ST_OVERFLOW;
                                end else begin
                                    w_we    = 1'b1;
                                    n_depth = r_depth + DW'(1);
                                end
                            end
                            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT: begin
                                if (r_depth < DW'(2)) begin
                                    n_err = ST_UNDERFLOW;
                                end else begin
                                    n_st = S_RDR;
                                    case (i_symbol)
                                        CH_PLUS:  n_op = OP_ADD;
                                        CH_MINUS: n_op = OP_SUB;
                                        CH_STAR:  n_op = OP_MUL;
                                        CH_SLASH: n_op = OP_DIV;
                                        default:  n_op = OP_REM;
                                    endcase
                                end
                            end
                            default: begin
                                n_err = ST_BAD_SYMBOL;
                            end
                        endcase
                    end
                end
            end
            S_RDR: begin
                n_right = r_rd_data;
                n_st    = S_RDL;
            end
            S_RDL: begin
                if ((r_op == OP_DIV || r_op == OP_REM) && r_right == '0) begin
                    n_err = ST_DIV_ZERO;
                    n_st  = S_IDLE;
                end else begin
                    w_alu_req.start = 1'b1;
                    n_st            = S_EXEC;
                end
            end
            S_EXEC: begin
                // result replaces the left operand, stack shrinks by one
                if (w_alu_done) begin
                    w_we      = 1'b1;
                    w_wr_addr = w_below_idx;
                    w_wr_data = w_alu_result;
                    n_depth   = r_depth - DW'(1);
                    n_st      = S_IDLE;
                end
            end
            S_TERM: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = w_term_status;
                    n_value     = (w_term_status == ST_OK) ? 32'($signed(r_rd_data)) : '0;
                    n_depth     = '0;
                    n_err       = ST_OK;
                    n_st        = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    // value stack memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_depth     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_depth     <= n_depth;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_op     <= n_op;
        r_right  <= n_right;
        r_value  <= n_value;
        r_status <= n_status;
    end

    pse_alu #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_left   (r_rd_data),
        .i_right  (r_right),
        .o_done   (w_alu_done),
        .o_result (w_alu_result)
    );

    assign o_valid  = r_out_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

    // stack depth stays within the memory
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // a failed expression never reports a value
    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_value == '0)
        else $error("nonzero value with error status");

    // arithmetic unit finishes only while the sequencer waits for it
    a_alu_done_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_done |-> r_st == S_EXEC)
        else $error("arithmetic result outside execute state");

    // a delivered result leaves an empty stack and no pending error
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_TERM && w_out_free |=> r_depth == '0 && r_err == ST_OK && o_valid)
        else $error("terminator did not clear evaluator state");

endmodule

`default_nettype wire

/* rtl/pse_alu.sv */
// Iterative arithmetic unit: one shared adder/subtractor does add, subtract,
// shift-add multiply and restoring signed divide/remainder.
// Depends on pse_pkg.
`default_nettype none

module pse_alu import pse_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_alu_req               i_req,
    input  wire logic [VALUE_WIDTH-1:0] i_left,
    input  wire logic [VALUE_WIDTH-1:0] i_right,
    output logic                        o_done,
    output logic [VALUE_WIDTH-1:0]      o_result
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(VALUE_WIDTH);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_ADD  = 3'd1;
    localparam logic [2:0] A_MUL  = 3'd2;
    localparam logic [2:0] A_NEGL = 3'd3;
    localparam logic [2:0] A_NEGR = 3'd4;
    localparam logic [2:0] A_DIV  = 3'd5;
    localparam logic [2:0] A_FIX  = 3'd6;

    logic [2:0]    r_st, n_st;
    t_op           r_op, n_op;
    logic [W-1:0]  r_a, n_a;     // sum, product accumulator, remainder, final result
    logic [W-1:0]  r_b, n_b;     // right operand, multiplicand, divisor
    logic [W-1:0]  r_c, n_c;     // multiplier, dividend/quotient
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ln, n_ln;   // left operand negative
    logic          r_rn, n_rn;   // right operand negative
    logic          r_done, n_done;

    logic [W:0]    w_add_a;
    logic [W:0]    w_add_b;
    logic          w_sub;
    logic [W:0]    w_sum;
    logic [W-1:0]  w_fix_val;
    logic          w_fix_neg;
    logic          w_last;

    // final sign correction picks quotient or remainder
    assign w_fix_val = (r_op == OP_DIV) ? r_c : r_a;
    assign w_fix_neg = (r_op == OP_DIV) ? (r_ln ^ r_rn) : r_ln;
    assign w_last    = (r_cnt == CW'(W - 1));

    // shared adder operand selection
    always_comb begin
        w_add_a = '0;
        w_add_b = '0;
        w_sub   = 1'b0;
        unique case (r_st)
            A_ADD: begin
                w_add_a = {1'b0, r_a};
                w_add_b = {1'b0, r_b};
                w_sub   = (r_op == OP_SUB);
            end
            A_MUL: begin
                w_add_a = {1'b0, r_a};
                w_add_b = r_c[0] ? {1'b0, r_b} : '0;
            end
            A_NEGL: begin
                w_add_b = {1'b0, r_a};
                w_sub   = 1'b1;
            end
            A_NEGR: begin
                w_add_b = {1'b0, r_b};
                w_sub   = 1'b1;
            end
            A_DIV: begin
                w_add_a = {r_a, r_c[W-1]};
                w_add_b = {1'b0, r_b};
                w_sub   = 1'b1;
            end
            A_FIX: begin
                w_add_b = {1'b0, w_fix_val};
                w_sub   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign w_sum = w_add_a + (w_add_b ^ {(W+1){w_sub}}) + (W+1)'(w_sub);

    // sequencer
    always_comb begin
        n_st   = r_st;
        n_op   = r_op;
        n_a    = r_a;
        n_b    = r_b;
        n_c    = r_c;
        n_cnt  = r_cnt;
        n_ln   = r_ln;
        n_rn   = r_rn;
        n_done = 1'b0;
        unique case (r_st)
            A_IDLE: begin
                if (i_req.start) begin
                    n_op  = i_req.op;
                    n_cnt = '0;
                    case (i_req.op) inside
                        OP_MUL: begin
                            n_a  = '0;
                            n_b  = i_left;
                            n_c  = i_right;
                            n_st = A_MUL;
                        end
                        OP_DIV, OP_REM: begin
                            n_a  = i_left;
                            n_b  = i_right;
                            n_ln = i_left[W-1];
                            n_rn = i_right[W-1];
                            n_st = A_NEGL;
                        end
                        default: begin
                            n_a  = i_left;
                            n_b  = i_right;
                            n_st = A_ADD;
                        end
                    endcase
                end
            end
            A_ADD: begin
                n_a    = w_sum[W-1:0];
                n_done = 1'b1;
                n_st   = A_IDLE;
            end
            A_MUL: begin
                // one multiplier bit per cycle
                n_a   = w_sum[W-1:0];
                n_b   = {r_b[W-2:0], 1'b0};
                n_c   = {1'b0, r_c[W-1:1]};
                n_cnt = r_cnt + CW'(1);
                if (w_last) begin
                    n_done = 1'b1;
                    n_st   = A_IDLE;
                end
            end
            A_NEGL: begin
                // dividend magnitude, remainder cleared
                n_c  = r_ln ? w_sum[W-1:0] : r_a;
                n_a  = '0;
                n_st = A_NEGR;
            end
            A_NEGR: begin
                n_b  = r_rn ? w_sum[W-1:0] : r_b;
                n_st = A_DIV;
            end
            A_DIV: begin
                // restoring step: one quotient bit per cycle
                n_a   = w_sum[W] ? {r_a[W-2:0], r_c[W-1]} : w_sum[W-1:0];
                n_c   = {r_c[W-2:0], ~w_sum[W]};
                n_cnt = r_cnt + CW'(1);
                if (w_last) begin
                    n_st = A_FIX;
                end
            end
            A_FIX: begin
                n_a    = w_fix_neg ? w_sum[W-1:0] : w_fix_val;
                n_done = 1'b1;
                n_st   = A_IDLE;
            end
            default: begin
                n_st = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= A_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_cnt <= n_cnt;
        r_ln  <= n_ln;
        r_rn  <= n_rn;
    end

    assign o_done   = r_done;
    assign o_result = r_a;

endmodule

`default_nettype wire
